FILE: hw/rtl/cnsb_pkg.sv
package cnsb_pkg;

	localparam int NUM_SEMS_DEF     = 8;
	localparam int WAIT_DEPTH_DEF   = 8;
	localparam int TASK_ID_BITS_DEF = 8;

	// command queue between front and back
	localparam int CMDQ_DEPTH = 2;

	localparam logic [31:0] COUNT_MAX = 32'hffff_ffff;

	typedef enum logic [1:0] {
		FUNC_INIT    = 2'd0,
		FUNC_PEND    = 2'd1,
		FUNC_POST    = 2'd2,
		FUNC_RELEASE = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		KIND_INIT,
		KIND_PEND,
		KIND_POST,
		KIND_RELEASE,
		KIND_BAD
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_WAITING     = 3'd1,
		ST_WOULD_BLOCK = 3'd2,
		ST_NOT_IN_USE  = 3'd3,
		ST_AT_MAX      = 3'd4,
		ST_QUEUE_FULL  = 3'd5,
		ST_NONE_FREE   = 3'd6
	} status_t;

	typedef struct packed {
		kind_t       kind;
		logic [2:0]  sem_index;
		logic [7:0]  task_id;
		logic        may_wait;
		logic [31:0] init_value;
	} cmd_t;

	typedef struct packed {
		logic       done;
		status_t    status;
		logic [2:0] sem_out;
		logic       woken_valid;
		logic [7:0] woken_task;
		logic       last;
	} res_t;

endpackage

FILE: hw/rtl/counting_semaphore_bank_unit.sv
// Channel   Direction  Handshake                 Payload
// command   in         start & !busy             func, sem_index, task_id, may_wait, init_value
// result    out        done (one-cycle strobe)   status, sem_out, woken_valid, woken_task, last
//
// A command transaction enters a two-entry queue, so busy rises only when two are waiting.
// Init, pend and post without a waiter pass through the execute engine as an entry read, then
// an update; post that wakes a waiter adds a wake step; release with n waiters walks them,
// one woken task per cycle, limited by the single read port of the waiter memory.
// Each result is registered in the cycle after the engine decides it and cannot be held off.
// arst_n clears all semaphores to free and empties the queue; no clearing pass is needed.
module counting_semaphore_bank_unit #(
	parameter int NUM_SEMS     = cnsb_pkg::NUM_SEMS_DEF,
	parameter int WAIT_DEPTH   = cnsb_pkg::WAIT_DEPTH_DEF,
	parameter int TASK_ID_BITS = cnsb_pkg::TASK_ID_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [2:0]  sem_index,
	input  logic [7:0]  task_id,
	input  logic        may_wait,
	input  logic [31:0] init_value,
	output logic        done,
	output logic [2:0]  status,
	output logic [2:0]  sem_out,
	output logic        woken_valid,
	output logic [7:0]  woken_task,
	output logic        last
);
	import cnsb_pkg::*;

	cmd_t push_cmd;
	cmd_t head_cmd;
	logic push;
	logic pop;
	logic full;
	logic empty;
	res_t res;

	// front: take the transaction and settle what needs no state
	cnsb_front #(
		.NUM_SEMS (NUM_SEMS)
	) u_front (
		.start      (start),
		.full       (full),
		.func       (func),
		.sem_index  (sem_index),
		.task_id    (task_id),
		.may_wait   (may_wait),
		.init_value (init_value),
		.push       (push),
		.cmd        (push_cmd)
	);

	// hold classified commands while the engine works
	cnsb_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (head_cmd),
		.full     (full),
		.empty    (empty)
	);

	// back: read-modify-write of one semaphore, walk waiters on wake
	cnsb_back #(
		.NUM_SEMS     (NUM_SEMS),
		.WAIT_DEPTH   (WAIT_DEPTH),
		.TASK_ID_BITS (TASK_ID_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (empty),
		.head_cmd (head_cmd),
		.pop      (pop),
		.res      (res)
	);

	assign busy        = full;
	assign done        = res.done;
	assign status      = res.status;
	assign sem_out     = res.sem_out;
	assign woken_valid = res.woken_valid;
	assign woken_task  = res.woken_task;
	assign last        = res.last;

	// any failing status ends the transaction in one result
	assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> last && !woken_valid)
		else $error("failing result not marked last");

	// a woken task only comes with an ok result
	assert property (@(posedge clk) disable iff (!arst_n)
		done && woken_valid |-> status == ST_OK && sem_out == 3'd0)
		else $error("woken task outside an ok result");

	// an allocated index only on an init, which never wakes anyone
	assert property (@(posedge clk) disable iff (!arst_n)
		done && sem_out != 3'd0 |-> status == ST_OK && !woken_valid && last)
		else $error("sem_out set on a result that is not an init");

	// a result not marked last is followed at once by the next wake of the release
	assert property (@(posedge clk) disable iff (!arst_n)
		done && !last |=> done && woken_valid)
		else $error("release wake sequence broken");

endmodule

FILE: hw/rtl/cnsb_front.sv
module cnsb_front #(
	parameter int NUM_SEMS = 8
) (
	input  logic          start,
	input  logic          full,
	input  logic [1:0]    func,
	input  logic [2:0]    sem_index,
	input  logic [7:0]    task_id,
	input  logic          may_wait,
	input  logic [31:0]   init_value,
	output logic          push,
	output cnsb_pkg::cmd_t cmd
);
	import cnsb_pkg::*;

	logic in_range;

	assign push     = start & ~full;
	assign in_range = {29'd0, sem_index} < 32'(NUM_SEMS);

	// classify: an out-of-range index is settled here, the rest needs state
	always_comb begin
		cmd.sem_index  = sem_index;
		cmd.task_id    = task_id;
		cmd.may_wait   = may_wait;
		cmd.init_value = init_value;
		unique case (func_t'(func))
			FUNC_INIT:    cmd.kind = KIND_INIT;
			FUNC_PEND:    cmd.kind = in_range ? KIND_PEND : KIND_BAD;
			FUNC_POST:    cmd.kind = in_range ? KIND_POST : KIND_BAD;
			FUNC_RELEASE: cmd.kind = in_range ? KIND_RELEASE : KIND_BAD;
			default:      cmd.kind = KIND_BAD;
		endcase
	end

endmodule

FILE: hw/rtl/cnsb_cmd_fifo.sv
module cnsb_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cnsb_pkg::cmd_t push_cmd,
	input  logic           pop,
	output cnsb_pkg::cmd_t pop_cmd,
	output logic           full,
	output logic           empty
);
	import cnsb_pkg::*;

	localparam int PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int CW = $clog2(CMDQ_DEPTH + 1);

	cmd_t          ent_q [CMDQ_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = cnt_q == CW'(CMDQ_DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign pop_cmd = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: hw/rtl/cnsb_back.sv
module cnsb_back #(
	parameter int NUM_SEMS     = 8,
	parameter int WAIT_DEPTH   = 8,
	parameter int TASK_ID_BITS = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           empty,
	input  cnsb_pkg::cmd_t head_cmd,
	output logic           pop,
	output cnsb_pkg::res_t res
);
	import cnsb_pkg::*;

	localparam int IW   = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
	localparam int HW   = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
	localparam int FW   = $clog2(WAIT_DEPTH + 1);
	localparam int SUMW = $clog2(2 * WAIT_DEPTH) > 0 ? $clog2(2 * WAIT_DEPTH) : 1;
	localparam int NW   = NUM_SEMS * WAIT_DEPTH;
	localparam int AW   = (NW > 1) ? $clog2(NW) : 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_WAKE
	} state_t;

	state_t                  state_q;
	cmd_t                    cmd_q;
	logic [IW-1:0]           idx_q;
	logic                    ok_q;
	logic [NUM_SEMS-1:0]     in_use_q;
	logic [FW-1:0]           left_q;
	logic [HW-1:0]           ptr_q;
	res_t                    res_q;

	logic [31:0]             cnt_mem  [NUM_SEMS];
	logic [HW-1:0]           head_mem [NUM_SEMS];
	logic [FW-1:0]           fill_mem [NUM_SEMS];
	logic [31:0]             cnt_rd_q;
	logic [HW-1:0]           head_rd_q;
	logic [FW-1:0]           fill_rd_q;

	logic [TASK_ID_BITS-1:0] wait_mem [NW];
	logic [TASK_ID_BITS-1:0] wait_rd_q;

	logic [IW-1:0]           free_idx;
	logic                    any_free;
	logic [IW-1:0]           next_idx;
	logic                    next_ok;
	logic [IW-1:0]           sm_rd_idx;

	logic                    sm_we;
	logic [31:0]             sm_cnt_d;
	logic [HW-1:0]           sm_head_d;
	logic [FW-1:0]           sm_fill_d;
	logic                    wq_we;
	logic [HW-1:0]           wq_slot;
	logic [AW-1:0]           base_addr;
	logic [AW-1:0]           wq_wr_addr;
	logic [AW-1:0]           wq_rd_addr;
	logic [HW-1:0]           head_next;
	status_t                 ex_status;
	logic                    ex_wake;
	logic                    set_use;
	logic                    clr_use;

	function automatic logic [HW-1:0] wrap(input logic [SUMW-1:0] s);
		logic [HW-1:0] r;
		if (s >= SUMW'(WAIT_DEPTH)) begin
			r = HW'(s - SUMW'(WAIT_DEPTH));
		end else begin
			r = HW'(s);
		end
		return r;
	endfunction

	// lowest free semaphore
	always_comb begin
		free_idx = '0;
		any_free = 1'b0;
		for (int i = NUM_SEMS - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				free_idx = IW'(i);
				any_free = 1'b1;
			end
		end
	end

	assign pop      = (state_q == S_IDLE) && !empty;
	assign next_idx = (head_cmd.kind == KIND_INIT) ? free_idx : IW'(head_cmd.sem_index);

	always_comb begin
		priority if (head_cmd.kind == KIND_INIT) begin
			next_ok = any_free;
		end else if (head_cmd.kind == KIND_BAD) begin
			next_ok = 1'b0;
		end else begin
			next_ok = in_use_q[IW'(head_cmd.sem_index)];
		end
	end

	// read the entry of the next command while it is popped
	assign sm_rd_idx  = (state_q == S_IDLE) ? next_idx : idx_q;
	assign head_next  = wrap(SUMW'(head_rd_q) + SUMW'(1));
	assign wq_slot    = wrap(SUMW'(head_rd_q) + SUMW'(fill_rd_q));
	assign base_addr  = AW'(idx_q) * AW'(WAIT_DEPTH);
	assign wq_wr_addr = base_addr + AW'(wq_slot);
	assign wq_rd_addr = base_addr + AW'((state_q == S_EXEC) ? head_rd_q : ptr_q);

	always_comb begin
		sm_we     = 1'b0;
		sm_cnt_d  = cnt_rd_q;
		sm_head_d = head_rd_q;
		sm_fill_d = fill_rd_q;
		wq_we     = 1'b0;
		ex_status = ST_OK;
		ex_wake   = 1'b0;
		set_use   = 1'b0;
		clr_use   = 1'b0;
		if (state_q == S_EXEC) begin
			if (!ok_q) begin
				ex_status = (cmd_q.kind == KIND_INIT) ? ST_NONE_FREE : ST_NOT_IN_USE;
			end else begin
				unique case (cmd_q.kind)
					KIND_INIT: begin
						set_use   = 1'b1;
						sm_we     = 1'b1;
						sm_cnt_d  = cmd_q.init_value;
						sm_head_d = '0;
						sm_fill_d = '0;
					end
					KIND_PEND: begin
						priority if (cnt_rd_q != '0) begin
							sm_we    = 1'b1;
							sm_cnt_d = cnt_rd_q - 32'd1;
						end else if (!cmd_q.may_wait) begin
							ex_status = ST_WOULD_BLOCK;
						end else if (fill_rd_q >= FW'(WAIT_DEPTH)) begin
							ex_status = ST_QUEUE_FULL;
						end else begin
							wq_we     = 1'b1;
							sm_we     = 1'b1;
							sm_fill_d = fill_rd_q + FW'(1);
							ex_status = ST_WAITING;
						end
					end
					KIND_POST: begin
						priority if (cnt_rd_q == COUNT_MAX) begin
							ex_status = ST_AT_MAX;
						end else if (fill_rd_q != '0) begin
							sm_we     = 1'b1;
							sm_head_d = head_next;
							sm_fill_d = fill_rd_q - FW'(1);
							ex_wake   = 1'b1;
						end else begin
							sm_we    = 1'b1;
							sm_cnt_d = cnt_rd_q + 32'd1;
						end
					end
					KIND_RELEASE: begin
						clr_use = 1'b1;
						ex_wake = fill_rd_q != '0;
					end
					default: ex_status = ST_NOT_IN_USE;
				endcase
			end
		end
	end

	// per-semaphore entry memory
	always_ff @(posedge clk) begin
		if (sm_we) begin
			cnt_mem[idx_q]  <= sm_cnt_d;
			head_mem[idx_q] <= sm_head_d;
			fill_mem[idx_q] <= sm_fill_d;
		end
		cnt_rd_q  <= cnt_mem[sm_rd_idx];
		head_rd_q <= head_mem[sm_rd_idx];
		fill_rd_q <= fill_mem[sm_rd_idx];
	end

	// waiter id memory
	always_ff @(posedge clk) begin
		if (wq_we) begin
			wait_mem[wq_wr_addr] <= TASK_ID_BITS'(cmd_q.task_id);
		end
		wait_rd_q <= wait_mem[wq_rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cmd_q    <= '0;
			idx_q    <= '0;
			ok_q     <= 1'b0;
			in_use_q <= '0;
			left_q   <= '0;
			ptr_q    <= '0;
			res_q    <= '0;
		end else begin
			res_q.done <= ((state_q == S_EXEC) && !ex_wake) || (state_q == S_WAKE);
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						cmd_q   <= head_cmd;
						idx_q   <= next_idx;
						ok_q    <= next_ok;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (set_use) begin
						in_use_q[idx_q] <= 1'b1;
					end
					if (clr_use) begin
						in_use_q[idx_q] <= 1'b0;
					end
					if (ex_wake) begin
						left_q  <= (cmd_q.kind == KIND_RELEASE) ? fill_rd_q : FW'(1);
						ptr_q   <= head_next;
						state_q <= S_WAKE;
					end else begin
						res_q.status      <= ex_status;
						res_q.sem_out     <= (ok_q && cmd_q.kind == KIND_INIT) ?
							3'(idx_q) : 3'd0;
						res_q.woken_valid <= 1'b0;
						res_q.woken_task  <= '0;
						res_q.last        <= 1'b1;
						state_q           <= S_IDLE;
					end
				end
				S_WAKE: begin
					res_q.status      <= ST_OK;
					res_q.sem_out     <= 3'd0;
					res_q.woken_valid <= 1'b1;
					res_q.woken_task  <= 8'(wait_rd_q);
					res_q.last        <= left_q == FW'(1);
					ptr_q             <= wrap(SUMW'(ptr_q) + SUMW'(1));
					left_q            <= left_q - FW'(1);
					if (left_q == FW'(1)) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res = res_q;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import cnsb_pkg::*;

	// Generous bound: every command waiting out the longest sender gap plus a
	// full release walk, taken several times over.
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int          NSEM        = NUM_SEMS_DEF;
	localparam int          QDEPTH      = WAIT_DEPTH_DEF;

	// One result the bank owes us, in the order the bank must emit it.
	typedef struct {
		status_t    status;
		logic [2:0] sem_out;
		bit         woken_valid;
		logic [7:0] woken_task;
		bit         last;
	} sem_reply_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  func;
	logic [2:0]  sem_index;
	logic [7:0]  task_id;
	logic        may_wait;
	logic [31:0] init_value;
	logic        done;
	logic [2:0]  status;
	logic [2:0]  sem_out;
	logic        woken_valid;
	logic [7:0]  woken_task;
	logic        last;

	// Shadow copy of the semaphore bank, advanced once per accepted transaction.
	logic [31:0] sem_cnt   [NSEM];
	bit          sem_used  [NSEM];
	logic [7:0]  wait_ids  [NSEM][QDEPTH];
	int          wait_head [NSEM];
	int          wait_fill [NSEM];

	sem_reply_t  replies_owed[$];

	int unsigned error_count;
	int unsigned cycle_count;
	int unsigned cmds_sent;
	int unsigned replies_seen;
	int unsigned wakes_seen;
	int unsigned status_hits [7];
	bit          no_gaps;

	counting_semaphore_bank_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.sem_index  (sem_index),
		.task_id    (task_id),
		.may_wait   (may_wait),
		.init_value (init_value),
		.done       (done),
		.status     (status),
		.sem_out    (sem_out),
		.woken_valid(woken_valid),
		.woken_task (woken_task),
		.last       (last)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Bail out if the bank stops answering.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic sem_reply_t mk_reply(status_t st, logic [2:0] so, bit wv,
			logic [7:0] wt, bit lst);
		sem_reply_t r;
		r.status      = st;
		r.sem_out     = so;
		r.woken_valid = wv;
		r.woken_task  = wt;
		r.last        = lst;
		return r;
	endfunction

	// Advance the shadow bank by one command and queue the results it owes.
	task automatic apply_sem_cmd(input func_t f, input logic [2:0] idx, input logic [7:0] tid,
			input bit mw, input logic [31:0] iv);
		bit found;
		int n;
		found = 1'b0;
		if (f == FUNC_INIT) begin
			// Take the lowest free semaphore; reset its count and queue.
			for (int i = 0; i < NSEM; i++) begin
				if (!found && !sem_used[i]) begin
					found        = 1'b1;
					sem_used[i]  = 1'b1;
					sem_cnt[i]   = iv;
					wait_head[i] = 0;
					wait_fill[i] = 0;
					replies_owed.push_back(mk_reply(ST_OK, 3'(i), 1'b0, 8'd0, 1'b1));
				end
			end
			if (!found)
				replies_owed.push_back(mk_reply(ST_NONE_FREE, 3'd0, 1'b0, 8'd0, 1'b1));
		end else if (!sem_used[idx]) begin
			replies_owed.push_back(mk_reply(ST_NOT_IN_USE, 3'd0, 1'b0, 8'd0, 1'b1));
		end else if (f == FUNC_PEND) begin
			if (sem_cnt[idx] != 32'd0) begin
				sem_cnt[idx] = sem_cnt[idx] - 32'd1;
				replies_owed.push_back(mk_reply(ST_OK, 3'd0, 1'b0, 8'd0, 1'b1));
			end else if (!mw) begin
				replies_owed.push_back(mk_reply(ST_WOULD_BLOCK, 3'd0, 1'b0, 8'd0, 1'b1));
			end else if (wait_fill[idx] >= QDEPTH) begin
				replies_owed.push_back(mk_reply(ST_QUEUE_FULL, 3'd0, 1'b0, 8'd0, 1'b1));
			end else begin
				// Append at the tail of the circular wait list.
				wait_ids[idx][(wait_head[idx] + wait_fill[idx]) % QDEPTH] = tid;
				wait_fill[idx]++;
				replies_owed.push_back(mk_reply(ST_WAITING, 3'd0, 1'b0, 8'd0, 1'b1));
			end
		end else if (f == FUNC_POST) begin
			// The saturation check wins even when tasks are waiting.
			if (sem_cnt[idx] == COUNT_MAX) begin
				replies_owed.push_back(mk_reply(ST_AT_MAX, 3'd0, 1'b0, 8'd0, 1'b1));
			end else if (wait_fill[idx] > 0) begin
				replies_owed.push_back(mk_reply(ST_OK, 3'd0, 1'b1,
					wait_ids[idx][wait_head[idx]], 1'b1));
				wait_head[idx] = (wait_head[idx] + 1) % QDEPTH;
				wait_fill[idx]--;
			end else begin
				sem_cnt[idx] = sem_cnt[idx] + 32'd1;
				replies_owed.push_back(mk_reply(ST_OK, 3'd0, 1'b0, 8'd0, 1'b1));
			end
		end else begin
			// Release: wake every waiter oldest first, one result each, then free.
			n = wait_fill[idx];
			if (n == 0)
				replies_owed.push_back(mk_reply(ST_OK, 3'd0, 1'b0, 8'd0, 1'b1));
			for (int i = 0; i < n; i++)
				replies_owed.push_back(mk_reply(ST_OK, 3'd0, 1'b1,
					wait_ids[idx][(wait_head[idx] + i) % QDEPTH], i == n - 1));
			sem_used[idx]  = 1'b0;
			sem_cnt[idx]   = 32'd0;
			wait_head[idx] = 0;
			wait_fill[idx] = 0;
		end
	endtask

	// Mostly back-to-back or short gaps, with the odd long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Present one command, hold it until the bank takes it, then predict.
	task automatic send_cmd(input func_t f, input logic [2:0] idx, input logic [7:0] tid,
			input bit mw, input logic [31:0] iv);
		int gap;
		start      <= 1'b1;
		func       <= f;
		sem_index  <= idx;
		task_id    <= tid;
		may_wait   <= mw;
		init_value <= iv;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		apply_sem_cmd(f, idx, tid, mw, iv);
		cmds_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop start and hold off until the bank has paid every result it owes.
	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (replies_owed.size() != 0)
			@(posedge clk);
	endtask

	// Build one command: mostly aimed at live semaphores, some pure noise.
	task automatic random_cmd();
		int live[$];
		int r;
		func_t f;
		logic [2:0] idx;
		logic [31:0] iv;
		for (int k = 0; k < NSEM; k++)
			if (sem_used[k])
				live.push_back(k);
		r = $urandom_range(0, 99);
		if (live.size() == 0 || r < 10)
			f = FUNC_INIT;
		else if (r < 52)
			f = FUNC_PEND;
		else if (r < 90)
			f = FUNC_POST;
		else
			f = FUNC_RELEASE;
		if (live.size() != 0 && $urandom_range(0, 9) != 0)
			idx = 3'(live[$urandom_range(0, live.size() - 1)]);
		else
			idx = 3'($urandom_range(0, NSEM - 1));
		// Keep counts small so pends block often; sometimes sit near saturation.
		case ($urandom_range(0, 9))
			0: iv = COUNT_MAX;
			1: iv = COUNT_MAX - 32'd1;
			2: iv = $urandom;
			default: iv = 32'($urandom_range(0, 3));
		endcase
		send_cmd(f, idx, 8'($urandom_range(0, 255)), $urandom_range(0, 9) != 0, iv);
	endtask

	// Fill the bank with count extremes, then ask once more with nothing free.
	task automatic test_allocation();
		send_cmd(FUNC_INIT, 3'd7, 8'hff, 1'b1, 32'h0000_0000);
		send_cmd(FUNC_INIT, 3'd0, 8'h00, 1'b0, COUNT_MAX);
		send_cmd(FUNC_INIT, 3'd5, 8'h5a, 1'b1, 32'h0000_0001);
		for (int i = 3; i < NSEM; i++)
			send_cmd(FUNC_INIT, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
				1'b1, $urandom);
		send_cmd(FUNC_INIT, 3'd0, 8'h00, 1'b1, 32'h0000_0000);
	endtask

	// Walk every status path but none-free on the semaphores handed out above (0, 1 and 2).
	task automatic test_status_paths();
		send_cmd(FUNC_POST, 3'd1, 8'h00, 1'b0, 32'd0);
		send_cmd(FUNC_PEND, 3'd2, 8'h11, 1'b0, 32'd0);
		send_cmd(FUNC_PEND, 3'd2, 8'h12, 1'b0, 32'd0);
		// Fill semaphore 0's wait list with edge ids, then overflow it.
		for (int i = 0; i < QDEPTH; i++)
			send_cmd(FUNC_PEND, 3'd0, (i == 0) ? 8'h00 : (i == 1) ? 8'hff : 8'(i * 37),
				1'b1, 32'd0);
		send_cmd(FUNC_PEND, 3'd0, 8'haa, 1'b1, 32'd0);
		send_cmd(FUNC_POST, 3'd0, 8'h00, 1'b1, 32'd0);
		send_cmd(FUNC_RELEASE, 3'd0, 8'h00, 1'b1, 32'd0);
		send_cmd(FUNC_POST, 3'd0, 8'h00, 1'b1, 32'd0);
		send_cmd(FUNC_RELEASE, 3'd0, 8'h00, 1'b1, 32'd0);
		send_cmd(FUNC_RELEASE, 3'd2, 8'h00, 1'b1, 32'd0);
		send_cmd(FUNC_INIT, 3'd0, 8'h00, 1'b1, 32'hdead_beef);
	endtask

	// Random mix, switching between idle-free stretches and gapped ones.
	task automatic test_random_traffic(input int n_cmds);
		for (int i = 0; i < n_cmds; i++) begin
			if (i % 40 == 0)
				no_gaps = ($urandom_range(0, 3) == 0);
			random_cmd();
		end
		no_gaps = 1'b0;
	endtask

	// Back-to-back commands to keep the command queue full and busy toggling.
	task automatic test_burst(input int n_cmds);
		no_gaps = 1'b1;
		for (int i = 0; i < n_cmds; i++)
			random_cmd();
		no_gaps = 1'b0;
	endtask

	// Match every strobed result against the oldest one owed.
	always @(posedge clk) begin
		sem_reply_t exp_r;
		if (arst_n && done) begin
			replies_seen++;
			if (status <= 3'd6)
				status_hits[status]++;
			if (woken_valid === 1'b1)
				wakes_seen++;
			if (replies_owed.size() == 0) begin
				$error("unexpected result: status %0d woken_valid %0d woken_task %0d",
					status, woken_valid, woken_task);
				error_count++;
			end else begin
				exp_r = replies_owed.pop_front();
				if (status !== exp_r.status) begin
					$error("status: expected %0d, got %0d", exp_r.status, status);
					error_count++;
				end
				if (sem_out !== exp_r.sem_out) begin
					$error("sem_out: expected %0d, got %0d", exp_r.sem_out, sem_out);
					error_count++;
				end
				if (woken_valid !== exp_r.woken_valid) begin
					$error("woken_valid: expected %0d, got %0d",
						exp_r.woken_valid, woken_valid);
					error_count++;
				end
				if (woken_task !== exp_r.woken_task) begin
					$error("woken_task: expected %0d, got %0d", exp_r.woken_task, woken_task);
					error_count++;
				end
				if (last !== exp_r.last) begin
					$error("last: expected %0d, got %0d", exp_r.last, last);
					error_count++;
				end
			end
		end
	end

	initial begin
		start       = 1'b0;
		func        = FUNC_INIT;
		sem_index   = 3'd0;
		task_id     = 8'd0;
		may_wait    = 1'b0;
		init_value  = 32'd0;
		arst_n      = 1'b0;
		error_count = 0;
		cycle_count = 0;
		no_gaps     = 1'b0;
		for (int i = 0; i < NSEM; i++) begin
			sem_cnt[i]   = 32'd0;
			sem_used[i]  = 1'b0;
			wait_head[i] = 0;
			wait_fill[i] = 0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_allocation();
		test_status_paths();
		test_random_traffic(150);
		// Let the bank go fully quiet once before resuming traffic.
		wait_drained();
		test_random_traffic(150);
		test_burst(40);

		// Drain remaining results, then allow a full release walk for strays.
		wait_drained();
		repeat (30) @(posedge clk);

		$display("Covered %0d commands, %0d results, %0d woken tasks",
			cmds_sent, replies_seen, wakes_seen);
		$display("Status mix ok %0d wait %0d block %0d unused %0d max %0d full %0d none %0d",
			status_hits[0], status_hits[1], status_hits[2], status_hits[3],
			status_hits[4], status_hits[5], status_hits[6]);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
